### rtl/core/rcdf_pkg.sv
// Package with shared constants, types and helper functions of the serial frame deframer.
package rcdf_pkg;

   localparam int MaxChannels = 16;
   localparam int StoreDepth  = 2 * MaxChannels;
   localparam int StoreAw     = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
   localparam int CountW      = $clog2(MaxChannels + 1);

   localparam int SyncBytes   = 9;
   localparam int HeaderBytes = 11;

   localparam logic [7:0] StartByte    = 8'h53;
   localparam logic [7:0] FuncCodeRst  = 8'hB1;

   localparam logic [1:0] KindChannel  = 2'd0;
   localparam logic [1:0] KindMismatch = 2'd1;
   localparam logic [1:0] KindNotice   = 2'd2;

   typedef struct packed {
      logic             start;
      logic [1:0]       kind;
      logic [7:0]       length;
   } frame_end_type;

   typedef struct packed {
      logic               en;
      logic [StoreAw-1:0] addr;
      logic [7:0]         data;
   } ram_wr_type;

   function automatic logic [7:0] sync_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h53;
         4'd1:    c = 8'h4B;
         4'd2:    c = 8'h59;
         4'd3:    c = 8'h44;
         4'd4:    c = 8'h52;
         4'd5:    c = 8'h4F;
         4'd6:    c = 8'h49;
         4'd7:    c = 8'h44;
         4'd8:    c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### rtl/core/rcdf_ifs.sv
// Channel interfaces for the byte input, the result output and the register write port.
interface rcdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcdf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [3:0]  channel_index;
   logic [15:0] channel_value;
   logic        last_of_frame;
   modport source (output valid, output result_kind, output channel_index,
                   output channel_value, output last_of_frame, input ready);
   modport sink   (input valid, input result_kind, input channel_index,
                   input channel_value, input last_of_frame, output ready);
endinterface

interface rcdf_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/rcdf_payload_ram.sv
// Synchronous payload byte store with one write port and one registered read port.
module rcdf_payload_ram (
   input  logic                        clock,
   input  rcdf_pkg::ram_wr_type        wr,
   input  logic [rcdf_pkg::StoreAw-1:0] rd_addr,
   output logic [7:0]                  rd_data
);
   import rcdf_pkg::*;

   logic [7:0] mem [StoreDepth];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/rcdf_frame_parser.sv
// Byte parser that hunts, checks the header, stores the payload and judges the check byte.
module rcdf_frame_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             func_code,
   output rcdf_pkg::ram_wr_type   wr,
   output rcdf_pkg::frame_end_type frame_end
);
   import rcdf_pkg::*;

   localparam logic [1:0] PhaseHunt   = 2'd0;
   localparam logic [1:0] PhaseHeader = 2'd1;
   localparam logic [1:0] PhaseBody   = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] count_ff, count_in;
   logic       sync_ok_ff, sync_ok_in;
   logic [7:0] func_ff, func_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] acc_ff, acc_in;
   logic       sync_ok_next;
   logic [7:0] count_inc;

   assign count_inc = count_ff + 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      sync_ok_in   = sync_ok_ff;
      func_in      = func_ff;
      len_in       = len_ff;
      acc_in       = acc_ff;
      sync_ok_next = sync_ok_ff;
      wr           = '0;
      frame_end    = '0;
      if (take) begin
         unique case (phase_ff)
            PhaseHunt: begin
               if (rx_byte == StartByte) begin
                  phase_in   = PhaseHeader;
                  count_in   = 8'd1;
                  sync_ok_in = 1'b1;
                  func_in    = 8'd0;
                  len_in     = 8'd0;
                  acc_in     = rx_byte;
               end
            end
            PhaseHeader: begin
               acc_in = acc_ff ^ rx_byte;
               if (count_ff < 8'(SyncBytes)) begin
                  if (rx_byte != sync_char(count_ff[3:0])) begin
                     sync_ok_next = 1'b0;
                  end
               end else if (count_ff == 8'(SyncBytes)) begin
                  func_in = rx_byte;
               end else begin
                  len_in = rx_byte;
               end
               sync_ok_in = sync_ok_next;
               count_in   = count_inc;
               if (count_inc >= 8'(HeaderBytes)) begin
                  if (sync_ok_next) begin
                     phase_in = PhaseBody;
                     count_in = 8'd0;
                  end else begin
                     phase_in   = PhaseHunt;
                     count_in   = 8'd0;
                     sync_ok_in = 1'b1;
                     func_in    = 8'd0;
                     len_in     = 8'd0;
                     acc_in     = 8'd0;
                  end
               end
            end
            PhaseBody: begin
               if (count_ff < len_ff) begin
                  acc_in   = acc_ff ^ rx_byte;
                  count_in = count_inc;
                  if ({1'b0, count_ff} < 9'(StoreDepth)) begin
                     wr.en   = 1'b1;
                     wr.addr = count_ff[StoreAw-1:0];
                     wr.data = rx_byte;
                  end
               end else begin
                  frame_end.start  = 1'b1;
                  frame_end.length = len_ff;
                  if (rx_byte != acc_ff) begin
                     frame_end.kind = KindMismatch;
                  end else if (func_ff == func_code && len_ff != 8'd0) begin
                     frame_end.kind = KindChannel;
                  end else begin
                     frame_end.kind = KindNotice;
                  end
                  phase_in   = PhaseHunt;
                  count_in   = 8'd0;
                  sync_ok_in = 1'b1;
                  func_in    = 8'd0;
                  len_in     = 8'd0;
                  acc_in     = 8'd0;
               end
            end
            default: begin
               phase_in   = PhaseHunt;
               count_in   = 8'd0;
               sync_ok_in = 1'b1;
               func_in    = 8'd0;
               len_in     = 8'd0;
               acc_in     = 8'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhaseHunt;
         count_ff   <= 8'd0;
         sync_ok_ff <= 1'b1;
         func_ff    <= 8'd0;
         len_ff     <= 8'd0;
         acc_ff     <= 8'd0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         sync_ok_ff <= sync_ok_in;
         func_ff    <= func_in;
         len_ff     <= len_in;
         acc_ff     <= acc_in;
      end
   end

endmodule

### rtl/core/rcdf_result_emitter.sv
// Result sequencer that reads channel byte pairs from the payload store and drives results.
module rcdf_result_emitter (
   input  logic                          clock,
   input  logic                          reset,
   input  rcdf_pkg::frame_end_type       frame_end,
   input  logic [7:0]                    rd_data,
   output logic [rcdf_pkg::StoreAw-1:0]  rd_addr,
   output logic                          busy,
   rcdf_rsp_if.source                    rsp
);
   import rcdf_pkg::*;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StRdHi = 2'd1;
   localparam logic [1:0] StRdLo = 2'd2;
   localparam logic [1:0] StOut  = 2'd3;

   logic [1:0]        st_ff, st_in;
   logic [CountW-1:0] j_ff, j_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic [7:0]        len_ff, len_in;
   logic [7:0]        hi_ff, hi_in;
   logic              valid_ff, valid_in;
   logic [1:0]        kind_ff, kind_in;
   logic [3:0]        idx_ff, idx_in;
   logic [15:0]       value_ff, value_in;
   logic              last_ff, last_in;

   logic [CountW-1:0] j_next;
   logic [CountW:0]   addr_hi_sel;
   logic [CountW:0]   addr_lo_sel;
   logic [CountW:0]   addr_nx_sel;
   logic [8:0]        len_plus;
   logic [7:0]        half;
   logic [CountW-1:0] count_clamped;
   logic [8:0]        lo_pos;
   logic              lo_valid;

   assign j_next        = j_ff + CountW'(1);
   assign addr_hi_sel   = {j_ff, 1'b0};
   assign addr_lo_sel   = {j_ff, 1'b1};
   assign addr_nx_sel   = {j_next, 1'b0};
   assign len_plus      = {1'b0, frame_end.length} + 9'd1;
   assign half          = len_plus[8:1];
   assign count_clamped = (half > 8'(MaxChannels)) ? CountW'(MaxChannels)
                                                   : half[CountW-1:0];
   assign lo_pos        = 9'(addr_lo_sel);
   assign lo_valid      = lo_pos < {1'b0, len_ff};

   always_comb begin
      unique case (st_ff)
         StIdle:  rd_addr = '0;
         StRdHi:  rd_addr = addr_lo_sel[StoreAw-1:0];
         StOut:   rd_addr = addr_nx_sel[StoreAw-1:0];
         default: rd_addr = addr_hi_sel[StoreAw-1:0];
      endcase
   end

   always_comb begin
      st_in    = st_ff;
      j_in     = j_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      hi_in    = hi_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      idx_in   = idx_ff;
      value_in = value_ff;
      last_in  = last_ff;
      unique case (st_ff)
         StIdle: begin
            if (frame_end.start) begin
               if (frame_end.kind == KindChannel) begin
                  st_in  = StRdHi;
                  j_in   = '0;
                  cnt_in = count_clamped;
                  len_in = frame_end.length;
               end else begin
                  st_in    = StOut;
                  valid_in = 1'b1;
                  kind_in  = frame_end.kind;
                  idx_in   = 4'd0;
                  value_in = 16'd0;
                  last_in  = 1'b1;
               end
            end
         end
         StRdHi: begin
            hi_in = rd_data;
            st_in = StRdLo;
         end
         StRdLo: begin
            st_in    = StOut;
            valid_in = 1'b1;
            kind_in  = KindChannel;
            idx_in   = 4'(j_ff);
            value_in = {hi_ff, lo_valid ? rd_data : 8'd0};
            last_in  = (j_next == cnt_ff);
         end
         StOut: begin
            if (rsp.ready) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  st_in = StIdle;
               end else begin
                  j_in  = j_next;
                  st_in = StRdHi;
               end
            end
         end
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= StIdle;
         valid_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         valid_ff <= valid_in;
      end
      j_ff     <= j_in;
      cnt_ff   <= cnt_in;
      len_ff   <= len_in;
      hi_ff    <= hi_in;
      kind_ff  <= kind_in;
      idx_ff   <= idx_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign busy              = (st_ff != StIdle);
   assign rsp.valid         = valid_ff;
   assign rsp.result_kind   = kind_ff;
   assign rsp.channel_index = idx_ff;
   assign rsp.channel_value = value_ff;
   assign rsp.last_of_frame = last_ff;

endmodule

### rtl/core/rc_serial_frame_deframer.sv
// Top level of the serial remote-control frame deframer.
// Each received byte is one beat on the request channel and is taken while no frame results
// are pending. The check byte of a frame ends it: a checksum error, another function code or
// an empty payload gives one result in the next cycle, and a channel frame gives up to 16
// channel values, each read as a byte pair from the payload store in states StRdHi and StRdLo
// and held in StOut until the result beat is taken. The request channel is held off until the
// last result of the frame has left. The function code register is written on the csr channel
// and resets to 0xB1. The user must write it only while the block is idle; it is not enforced.
module rc_serial_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   rcdf_req_if.sink    req_port,
   rcdf_rsp_if.source  rsp_port,
   rcdf_csr_if.sink    csr_port
);
   import rcdf_pkg::*;

   logic [7:0]         func_code_ff;
   logic               take;
   logic               busy;
   ram_wr_type         wr;
   frame_end_type      frame_end;
   logic [StoreAw-1:0] rd_addr;
   logic [7:0]         rd_data;

   assign csr_port.ready = 1'b1;
   assign req_port.ready = !busy;
   assign take           = req_port.valid && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         func_code_ff <= FuncCodeRst;
      end else if (csr_port.valid) begin
         func_code_ff <= csr_port.data;
      end
   end

   rcdf_frame_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_port.rx_byte),
      .func_code (func_code_ff),
      .wr        (wr),
      .frame_end (frame_end)
   );

   rcdf_payload_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rcdf_result_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .frame_end (frame_end),
      .rd_data   (rd_data),
      .rd_addr   (rd_addr),
      .busy      (busy),
      .rsp       (rsp_port)
   );

endmodule
